### rtl/pai_pkg.sv
// Shared types and constants for the polygon area and inertia block.
package pai_pkg;

	localparam int COORD_W     = 16;
	localparam int FRAC_W      = 16;
	localparam int CROSS_W     = 41;
	localparam int INER_W      = 64;
	localparam int AREA_W      = 40;
	localparam int UINER_W     = 34;
	localparam int C_W         = 2 * COORD_W + 1;
	localparam int S_W         = 2 * COORD_W + 1;
	localparam int MA_W        = C_W + 1;
	localparam int MB_W        = S_W - FRAC_W + 1;
	localparam int PROD_W      = MA_W + MB_W;
	localparam int DVD_W       = INER_W + FRAC_W;
	localparam int DEN_W       = CROSS_W + 2;
	localparam int Q_W         = UINER_W + 1;
	localparam int DIV_STEPS   = DVD_W;
	localparam int STEP_W      = $clog2(DIV_STEPS);
	localparam int EDGE_LAST   = 12;
	localparam int IN_TDATA_W  = 2 * COORD_W;
	localparam int OUT_TDATA_W = ((AREA_W + UINER_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE,
		ST_PREP,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		MOP_NONE,
		MOP_AXBY,
		MOP_BXAY,
		MOP_AXAX,
		MOP_AYAY,
		MOP_BXBX,
		MOP_BYBY,
		MOP_AXBX,
		MOP_AYBY,
		MOP_CSH,
		MOP_CSL
	} mop_t;

	typedef struct packed {
		logic accept;
		logic load_first;
		logic edge_close;
		mop_t mop;
		logic commit;
		logic load_prev;
		logic prep;
		logic div_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic zero;
		logic out_free;
	} dp_stat_t;

endpackage

### rtl/pai_ctrl.sv
// Controller: sequences edge products, closing edge, divide and result load.
module pai_ctrl import pai_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_last,
	input  dp_stat_t stat,
	output logic     in_ready,
	output dp_cmd_t  cmd
);

	state_t              state_q, state_d;
	logic [STEP_W-1:0]   cnt_q, cnt_d;
	logic                have_first_q, have_first_d;
	logic                last_q, last_d;
	logic                close_q, close_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			have_first_q <= 1'b0;
			last_q       <= 1'b0;
			close_q      <= 1'b0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			have_first_q <= have_first_d;
			last_q       <= last_d;
			close_q      <= close_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		have_first_d   = have_first_q;
		last_d         = last_q;
		close_d        = close_q;
		cmd            = '0;
		cmd.mop        = MOP_NONE;
		cmd.edge_close = close_q;
		in_ready       = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					last_d     = in_last;
					cnt_d      = '0;
					if (have_first_q) begin
						close_d = 1'b0;
						state_d = ST_EDGE;
					end else begin
						// first vertex: no edge yet, unless it also closes
						have_first_d   = 1'b1;
						cmd.load_first = 1'b1;
						if (in_last) begin
							close_d = 1'b1;
							state_d = ST_EDGE;
						end
					end
				end
			end
			ST_EDGE: begin
				cnt_d = cnt_q + 1'b1;
				case (cnt_q)
					STEP_W'(0):  cmd.mop = MOP_AXBY;
					STEP_W'(1):  cmd.mop = MOP_BXAY;
					STEP_W'(2):  cmd.mop = MOP_AXAX;
					STEP_W'(3):  cmd.mop = MOP_AYAY;
					STEP_W'(4):  cmd.mop = MOP_BXBX;
					STEP_W'(5):  cmd.mop = MOP_BYBY;
					STEP_W'(6):  cmd.mop = MOP_AXBX;
					STEP_W'(7):  cmd.mop = MOP_AYBY;
					STEP_W'(9):  cmd.mop = MOP_CSH;
					STEP_W'(10): cmd.mop = MOP_CSL;
					default:     cmd.mop = MOP_NONE;
				endcase
				if (cnt_q == STEP_W'(EDGE_LAST)) begin
					cmd.commit = 1'b1;
					cnt_d      = '0;
					if (!close_q) begin
						cmd.load_prev = 1'b1;
						if (last_q) begin
							close_d = 1'b1;
						end else begin
							state_d = ST_IDLE;
						end
					end else begin
						state_d = ST_PREP;
					end
				end
			end
			ST_PREP: begin
				cmd.prep     = 1'b1;
				cnt_d        = '0;
				have_first_d = 1'b0;
				// skip the divide when the cross sum is zero
				state_d      = stat.zero ? ST_OUT : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/pai_dp.sv
// Datapath: shared multiplier, edge accumulators, restoring divider, result register.
module pai_dp import pai_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [COORD_W-1:0] in_x,
	input  logic signed [COORD_W-1:0] in_y,
	input  dp_cmd_t                   cmd,
	input  logic                      out_ready,
	output dp_stat_t                  stat,
	output logic                      out_valid,
	output logic [AREA_W-1:0]         out_area,
	output logic [UINER_W-1:0]        out_inertia,
	output logic                      out_degen
);

	localparam logic signed [CROSS_W-1:0] CROSS_MAX = {1'b0, {(CROSS_W-1){1'b1}}};
	localparam logic signed [CROSS_W-1:0] CROSS_MIN = {1'b1, {(CROSS_W-1){1'b0}}};
	localparam logic signed [INER_W-1:0]  INER_MAX  = {1'b0, {(INER_W-1){1'b1}}};
	localparam logic signed [INER_W-1:0]  INER_MIN  = {1'b1, {(INER_W-1){1'b0}}};
	localparam logic [UINER_W-1:0]        UI_MAX    = {1'b0, {(UINER_W-1){1'b1}}};
	localparam logic [UINER_W-1:0]        UI_MIN    = {1'b1, {(UINER_W-1){1'b0}}};

	logic signed [COORD_W-1:0] in_x_q, in_y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_W-1:0] ax, ay, bx, by;
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_s1;
	mop_t                      op_s1;
	logic signed [C_W-1:0]     c_q;
	logic [S_W-1:0]            s_q;
	logic signed [PROD_W-1:0]  term_q;
	logic signed [CROSS_W-1:0] cross_q;
	logic signed [INER_W-1:0]  iner_q;
	logic signed [CROSS_W:0]   cross_sum;
	logic signed [INER_W:0]    iner_sum;
	logic signed [CROSS_W-1:0] cross_sat;
	logic signed [INER_W-1:0]  iner_sat;
	logic [CROSS_W-1:0]        cross_abs;
	logic [INER_W-1:0]         iner_abs;
	logic [DEN_W-1:0]          den_q, rem_q;
	logic [DVD_W-1:0]          dvd_q;
	logic [Q_W-1:0]            quo_q;
	logic                      ovf_q, neg_q, degen_q;
	logic [AREA_W-1:0]         area_q;
	logic [DEN_W:0]            trial, trial_sub;
	logic                      ge;
	logic                      pos_big, neg_big;
	logic [UINER_W-1:0]        iner_res;
	logic                      out_valid_q;
	logic [AREA_W-1:0]         out_area_q;
	logic [UINER_W-1:0]        out_iner_q;
	logic                      out_degen_q;

	// Edge endpoints: the closing edge runs from the last vertex back to the first.
	assign ax = cmd.edge_close ? in_x_q    : prev_x_q;
	assign ay = cmd.edge_close ? in_y_q    : prev_y_q;
	assign bx = cmd.edge_close ? first_x_q : in_x_q;
	assign by = cmd.edge_close ? first_y_q : in_y_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mop)
			MOP_AXBY: begin
				mul_a = {{(MA_W-COORD_W){ax[COORD_W-1]}}, ax};
				mul_b = {{(MB_W-COORD_W){by[COORD_W-1]}}, by};
			end
			MOP_BXAY: begin
				mul_a = {{(MA_W-COORD_W){bx[COORD_W-1]}}, bx};
				mul_b = {{(MB_W-COORD_W){ay[COORD_W-1]}}, ay};
			end
			MOP_AXAX: begin
				mul_a = {{(MA_W-COORD_W){ax[COORD_W-1]}}, ax};
				mul_b = {{(MB_W-COORD_W){ax[COORD_W-1]}}, ax};
			end
			MOP_AYAY: begin
				mul_a = {{(MA_W-COORD_W){ay[COORD_W-1]}}, ay};
				mul_b = {{(MB_W-COORD_W){ay[COORD_W-1]}}, ay};
			end
			MOP_BXBX: begin
				mul_a = {{(MA_W-COORD_W){bx[COORD_W-1]}}, bx};
				mul_b = {{(MB_W-COORD_W){bx[COORD_W-1]}}, bx};
			end
			MOP_BYBY: begin
				mul_a = {{(MA_W-COORD_W){by[COORD_W-1]}}, by};
				mul_b = {{(MB_W-COORD_W){by[COORD_W-1]}}, by};
			end
			MOP_AXBX: begin
				mul_a = {{(MA_W-COORD_W){ax[COORD_W-1]}}, ax};
				mul_b = {{(MB_W-COORD_W){bx[COORD_W-1]}}, bx};
			end
			MOP_AYBY: begin
				mul_a = {{(MA_W-COORD_W){ay[COORD_W-1]}}, ay};
				mul_b = {{(MB_W-COORD_W){by[COORD_W-1]}}, by};
			end
			MOP_CSH: begin
				mul_a = {{(MA_W-C_W){c_q[C_W-1]}}, c_q};
				mul_b = {1'b0, s_q[S_W-1:FRAC_W]};
			end
			MOP_CSL: begin
				mul_a = {{(MA_W-C_W){c_q[C_W-1]}}, c_q};
				mul_b = {{(MB_W-FRAC_W){1'b0}}, s_q[FRAC_W-1:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= MOP_NONE;
		end else begin
			op_s1 <= cmd.mop;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		if (cmd.accept) begin
			in_x_q <= in_x;
			in_y_q <= in_y;
		end
		if (cmd.load_first) begin
			first_x_q <= in_x;
			first_y_q <= in_y;
			prev_x_q  <= in_x;
			prev_y_q  <= in_y;
		end else if (cmd.load_prev) begin
			prev_x_q <= in_x_q;
			prev_y_q <= in_y_q;
		end
		// Fold each registered product into the edge terms.
		case (op_s1)
			MOP_AXBY: c_q    <= prod_s1[C_W-1:0];
			MOP_BXAY: c_q    <= c_q - prod_s1[C_W-1:0];
			MOP_AXAX: s_q    <= prod_s1[S_W-1:0];
			MOP_AYAY,
			MOP_BXBX,
			MOP_BYBY,
			MOP_AXBX,
			MOP_AYBY: s_q    <= s_q + prod_s1[S_W-1:0];
			MOP_CSH:  term_q <= prod_s1;
			MOP_CSL:  term_q <= term_q + (prod_s1 >>> FRAC_W);
			default: begin
			end
		endcase
	end

	// Saturating accumulation of cross and inertia sums.
	assign cross_sum = {cross_q[CROSS_W-1], cross_q} + {{(CROSS_W+1-C_W){c_q[C_W-1]}}, c_q};
	assign iner_sum  = {iner_q[INER_W-1], iner_q} + {{(INER_W+1-PROD_W){term_q[PROD_W-1]}}, term_q};

	always_comb begin
		if (cross_sum[CROSS_W] != cross_sum[CROSS_W-1]) begin
			cross_sat = cross_sum[CROSS_W] ? CROSS_MIN : CROSS_MAX;
		end else begin
			cross_sat = cross_sum[CROSS_W-1:0];
		end
		if (iner_sum[INER_W] != iner_sum[INER_W-1]) begin
			iner_sat = iner_sum[INER_W] ? INER_MIN : INER_MAX;
		end else begin
			iner_sat = iner_sum[INER_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cross_q <= '0;
			iner_q  <= '0;
		end else if (cmd.commit) begin
			cross_q <= cross_sat;
			iner_q  <= iner_sat;
		end else if (cmd.prep) begin
			cross_q <= '0;
			iner_q  <= '0;
		end
	end

	assign cross_abs = cross_q[CROSS_W-1] ? -cross_q : cross_q;
	assign iner_abs  = iner_q[INER_W-1] ? -iner_q : iner_q;

	// One quotient bit per cycle; remainder always stays below the divisor.
	assign trial     = {rem_q, dvd_q[DVD_W-1]};
	assign ge        = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			den_q   <= {cross_abs, 2'b00} + {1'b0, cross_abs, 1'b0};
			dvd_q   <= {iner_abs, {FRAC_W{1'b0}}};
			rem_q   <= '0;
			quo_q   <= '0;
			ovf_q   <= 1'b0;
			neg_q   <= iner_q[INER_W-1] ^ cross_q[CROSS_W-1];
			degen_q <= (cross_q == '0);
			area_q  <= cross_q[AREA_W:1];
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[Q_W-1];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
		end
	end

	assign pos_big = ovf_q | quo_q[Q_W-1] | quo_q[UINER_W-1];
	assign neg_big = ovf_q | quo_q[Q_W-1] | (quo_q[UINER_W-1] & (|quo_q[UINER_W-2:0]));

	always_comb begin
		if (degen_q) begin
			iner_res = '0;
		end else if (!neg_q) begin
			iner_res = pos_big ? UI_MAX : quo_q[UINER_W-1:0];
		end else begin
			iner_res = neg_big ? UI_MIN : -quo_q[UINER_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_area_q  <= area_q;
			out_iner_q  <= iner_res;
			out_degen_q <= degen_q;
		end
	end

	assign stat.zero     = (cross_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_area      = out_area_q;
	assign out_inertia   = out_iner_q;
	assign out_degen     = out_degen_q;

endmodule

### rtl/polygon_area_and_inertia.sv
// Top level: polygon shoelace area and unit moment of inertia, stream in and out.
// Each edge runs ten products on the shared 34x18 multiplier, then a commit.
// A first vertex leaves the input ready unless it is last; a later vertex stalls
// the input until its edge commits. A last vertex adds the closing edge, a setup step,
// the one-bit divider (skipped when degenerate) and a load once the output is free.
// arst_n clears the sums, the first-vertex flag and the output valid at once.
module polygon_area_and_inertia import pai_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // vertex_x, vertex_y
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // signed_area, unit_inertia, zero pad
	output logic [0:0]             m_axis_tuser   // degenerate
);

	dp_cmd_t              cmd;
	dp_stat_t             stat;
	logic [AREA_W-1:0]    area;
	logic [UINER_W-1:0]   inertia;
	logic                 degen;

	pai_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.stat     (stat),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	pai_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_x        (s_axis_tdata[COORD_W-1:0]),
		.in_y        (s_axis_tdata[2*COORD_W-1:COORD_W]),
		.cmd         (cmd),
		.out_ready   (m_axis_tready),
		.stat        (stat),
		.out_valid   (m_axis_tvalid),
		.out_area    (area),
		.out_inertia (inertia),
		.out_degen   (degen)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W-AREA_W-UINER_W){1'b0}}, inertia, area};
	assign m_axis_tuser = degen;

endmodule

### rtl/pai_checker.sv
// Port-level checks for the polygon area and inertia block, bound to the top level.
module pai_checker import pai_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                   s_axis_tlast,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [0:0]             m_axis_tuser
);

	// no result beat once reset has been seen at an edge
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result beat changed");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[AREA_W +: UINER_W] == '0)
		else $error("degenerate result with nonzero inertia");

	// closing a polygon must stall the input for the closing edge
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken right after a last vertex");

	a_result_loads_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared while input was open");

endmodule

bind polygon_area_and_inertia pai_checker u_pai_checker (.*);

### bench/polygon_area_and_inertia_checker.sv
// Stream watcher for the polygon block: predicts each closed polygon's result and checks it.
`timescale 1ns / 100ps
module polygon_area_and_inertia_checker import pai_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // vertex_x, vertex_y
	input  logic                   s_axis_tlast,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // signed_area, unit_inertia, zero pad
	input  logic [0:0]             m_axis_tuser,  // degenerate
	output int                     mismatches,
	output int                     results_due,
	output int                     vertices_seen,
	output int                     polygons_seen,
	output int                     degenerate_seen,
	output int                     clipped_seen
);

	typedef struct packed {
		logic [AREA_W-1:0]  area;
		logic [UINER_W-1:0] inertia;
		logic               degenerate;
	} polygon_result_t;

	localparam longint       CROSS_TOP = (longint'(1) <<< (CROSS_W - 1)) - 1;
	localparam longint       CROSS_BOT = -CROSS_TOP - 1;
	localparam longint       MOMENT_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint       MOMENT_BOT = -MOMENT_TOP - 1;
	localparam logic [127:0] UINER_TOP = (128'd1 << (UINER_W - 1)) - 1;

	polygon_result_t polygon_results[$];

	longint first_x, first_y, prev_x, prev_y;
	bit     open_polygon;
	longint cross_acc;
	longint moment_acc;
	bit     clipped;
	int     n_mismatch, n_vertices, n_polygons, n_degenerate, n_clipped;

	// Add one edge a->b: shoelace cross and its inertia term, both saturating.
	function automatic void add_edge(input longint ax, input longint ay,
			input longint bx, input longint by);
		longint c, s, s_hi, s_lo, term, cs;
		c    = ax * by - bx * ay;
		s    = ax * ax + ay * ay + ax * bx + ay * by + bx * bx + by * by;
		s_hi = s >>> FRAC_W;
		s_lo = s & 64'hFFFF;
		term = c * s_hi + ((c * s_lo) >>> FRAC_W);
		cs   = cross_acc + c;
		if (cs > CROSS_TOP) begin
			cs = CROSS_TOP;
			clipped = 1'b1;
		end else if (cs < CROSS_BOT) begin
			cs = CROSS_BOT;
			clipped = 1'b1;
		end
		cross_acc = cs;
		if (term > 0 && moment_acc > MOMENT_TOP - term) begin
			moment_acc = MOMENT_TOP;
			clipped = 1'b1;
		end else if (term < 0 && moment_acc < MOMENT_BOT - term) begin
			moment_acc = MOMENT_BOT;
			clipped = 1'b1;
		end else begin
			moment_acc += term;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		longint          vx, vy;
		bit              neg;
		logic [63:0]     num, den;
		logic [127:0]    quo;
		polygon_result_t due, got;
		if (!arst_n) begin
			polygon_results.delete();
			open_polygon = 1'b0;
			cross_acc = 0;
			moment_acc = 0;
			clipped = 1'b0;
			n_mismatch = 0;
			n_vertices = 0;
			n_polygons = 0;
			n_degenerate = 0;
			n_clipped = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				vx = longint'($signed(s_axis_tdata[COORD_W-1:0]));
				vy = longint'($signed(s_axis_tdata[IN_TDATA_W-1:COORD_W]));
				n_vertices++;
				if (!open_polygon) begin
					first_x = vx;
					first_y = vy;
					open_polygon = 1'b1;
				end else begin
					add_edge(prev_x, prev_y, vx, vy);
				end
				prev_x = vx;
				prev_y = vy;
				if (s_axis_tlast) begin
					// close back to the first vertex
					add_edge(vx, vy, first_x, first_y);
					due.area = AREA_W'(cross_acc >>> 1);
					due.degenerate = (cross_acc == 0);
					due.inertia = '0;
					if (!due.degenerate) begin
						neg = (moment_acc < 0) != (cross_acc < 0);
						num = (moment_acc < 0) ? -moment_acc : moment_acc;
						den = 64'd6 * ((cross_acc < 0) ? -cross_acc : cross_acc);
						quo = {48'd0, num, 16'd0} / {64'd0, den};
						if (!neg && quo > UINER_TOP) begin
							quo = UINER_TOP;
							clipped = 1'b1;
						end else if (neg && quo > UINER_TOP + 1) begin
							quo = UINER_TOP + 1;
							clipped = 1'b1;
						end
						if (neg)
							quo = -quo;
						due.inertia = quo[UINER_W-1:0];
					end else begin
						n_degenerate++;
					end
					if (clipped)
						n_clipped++;
					n_polygons++;
					polygon_results.push_back(due);
					open_polygon = 1'b0;
					cross_acc = 0;
					moment_acc = 0;
					clipped = 1'b0;
				end
			end

			if (m_axis_tvalid && m_axis_tready) begin
				got.area = m_axis_tdata[AREA_W-1:0];
				got.inertia = m_axis_tdata[AREA_W +: UINER_W];
				got.degenerate = m_axis_tuser[0];
				if (polygon_results.size() == 0) begin
					$error("result beat with no closed polygon pending: signed_area %0d",
						$signed(got.area));
					n_mismatch++;
				end else begin
					due = polygon_results.pop_front();
					if (got.area !== due.area) begin
						$error("signed_area: expected %0d, got %0d",
							$signed(due.area), $signed(got.area));
						n_mismatch++;
					end
					if (got.inertia !== due.inertia) begin
						$error("unit_inertia: expected %0d, got %0d",
							$signed(due.inertia), $signed(got.inertia));
						n_mismatch++;
					end
					if (got.degenerate !== due.degenerate) begin
						$error("degenerate: expected %0b, got %0b",
							due.degenerate, got.degenerate);
						n_mismatch++;
					end
					if (m_axis_tdata[OUT_TDATA_W-1:AREA_W+UINER_W] !== '0) begin
						$error("tdata pad: expected 0, got %h",
							m_axis_tdata[OUT_TDATA_W-1:AREA_W+UINER_W]);
						n_mismatch++;
					end
				end
			end
		end
		mismatches      <= n_mismatch;
		results_due     <= polygon_results.size();
		vertices_seen   <= n_vertices;
		polygons_seen   <= n_polygons;
		degenerate_seen <= n_degenerate;
		clipped_seen    <= n_clipped;
	end

endmodule

### bench/polygon_area_and_inertia_tb.sv
// Bench top: clock, reset, vertex stimulus, result-side stalls and the final verdict.
`timescale 1ns / 100ps
module polygon_area_and_inertia_tb;
	import pai_pkg::*;

	typedef enum int {
		CM_FULL,
		CM_CORNER,
		CM_NEAR
	} coord_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]             m_axis_tuser;

	int mismatches, results_due, vertices_seen, polygons_seen, degenerate_seen, clipped_seen;

	int src_idle = 16;
	int dst_idle = 81;
	int sent = 0;

	logic [COORD_W-1:0] corner_vals [6] = '{16'h8000, 16'h8001, 16'hFFFF,
		16'h0000, 16'h0001, 16'h7FFF};

	always #10 clk = ~clk;

	polygon_area_and_inertia i_dut (.*);

	polygon_area_and_inertia_checker i_checker (.*);

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= dst_idle);

	// Present one vertex and hold it until the block takes the beat.
	task automatic put_vertex(input logic [COORD_W-1:0] vx, input logic [COORD_W-1:0] vy,
			input logic last);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {vy, vx};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
	endtask

	// Go round the full-range square many times so the cross sum runs into its limit.
	task automatic send_laps(input int laps, input bit clockwise);
		logic [COORD_W-1:0] cx [4];
		logic [COORD_W-1:0] cy [4];
		int k;
		cx = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000};
		cy = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF};
		for (int i = 0; i < 4 * laps; i++) begin
			k = clockwise ? 3 - (i % 4) : i % 4;
			put_vertex(cx[k], cy[k], i == 4 * laps - 1);
		end
	endtask

	function automatic logic [COORD_W-1:0] pick_coord(input coord_mode_t mode);
		case (mode)
			CM_CORNER: return corner_vals[$urandom_range(5)];
			CM_NEAR:   return COORD_W'($urandom_range(1024) - 512);
			default:   return COORD_W'($urandom);
		endcase
	endfunction

	initial begin
		int                 n;
		int                 stop_at;
		coord_mode_t        mode;
		bit                 line_up;
		logic [COORD_W-1:0] vx, vy;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit square, counterclockwise then clockwise
		put_vertex(16'h0000, 16'h0000, 1'b0);
		put_vertex(16'h0100, 16'h0000, 1'b0);
		put_vertex(16'h0100, 16'h0100, 1'b0);
		put_vertex(16'h0000, 16'h0100, 1'b1);
		put_vertex(16'h0000, 16'h0000, 1'b0);
		put_vertex(16'h0000, 16'h0100, 1'b0);
		put_vertex(16'h0100, 16'h0100, 1'b0);
		put_vertex(16'h0100, 16'h0000, 1'b1);
		// lone vertex closes onto itself
		put_vertex(16'h7FFF, 16'h8000, 1'b1);
		// two vertices: the closing edge cancels the first
		put_vertex(16'h8000, 16'h7FFF, 1'b0);
		put_vertex(16'h7FFF, 16'h8000, 1'b1);
		// triangle on the coordinate extremes
		put_vertex(16'h8000, 16'h8000, 1'b0);
		put_vertex(16'h7FFF, 16'h8000, 1'b0);
		put_vertex(16'h7FFF, 16'h7FFF, 1'b1);
		// figure eight, far lobe outweighs the near one: inertia clips high
		put_vertex(16'h0000, 16'h0000, 1'b0);
		put_vertex(16'h7FFF, 16'hFFFF, 1'b0);
		put_vertex(16'h7FFF, 16'h0001, 1'b0);
		put_vertex(16'h0000, 16'h0000, 1'b0);
		put_vertex(16'h0102, 16'h007F, 1'b0);
		put_vertex(16'h0102, 16'hFF81, 1'b1);
		// same with the far lobe reversed: inertia clips low
		put_vertex(16'h0000, 16'h0000, 1'b0);
		put_vertex(16'h7FFF, 16'h0001, 1'b0);
		put_vertex(16'h7FFF, 16'hFFFF, 1'b0);
		put_vertex(16'h0000, 16'h0000, 1'b0);
		put_vertex(16'h0100, 16'hFF80, 1'b0);
		put_vertex(16'h0100, 16'h0080, 1'b1);

		for (int phase = 0; phase < 3; phase++) begin
			src_idle = (phase == 0) ? 16 : (phase == 1) ? 81 : 0;
			dst_idle = (phase == 0) ? 81 : (phase == 1) ? 16 : 0;
			if (phase > 0)
				send_laps(132, phase == 2);
			stop_at = sent + 56;
			while (sent < stop_at) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
				mode = coord_mode_t'($urandom_range(2));
				line_up = ($urandom_range(11) == 0);
				for (int i = 0; i < n; i++) begin
					vx = pick_coord(mode);
					vy = line_up ? vx : pick_coord(mode);
					put_vertex(vx, vy, i == n - 1);
				end
			end
			// drain every pending result before the next mix
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while (results_due != 0)
				@(posedge clk);
		end

		repeat (150) @(posedge clk);
		$display("Covered %0d vertices in %0d polygons: %0d degenerate, %0d with clipped sums",
			vertices_seen, polygons_seen, degenerate_seen, clipped_seen);
		$display("Stall mixes: sender 16%%/receiver 81%%, then 81%%/16%%, then none");
		if (mismatches == 0 && results_due == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#20ms;
		$error("run timed out with %0d results still due", results_due);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
